// File: rtl/core/cpg_pkg.sv
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared constants, types and helpers for the circle point generator.
// ----------------------------------------------------------------------------
package cpg_pkg;

    localparam int unsigned COORD_BITS_DEF      = 16;
    localparam int unsigned ANGLE_FRAC_BITS_DEF = 24;

    localparam int unsigned RADIUS_W   = 15;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned INDEX_W    = 8;
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned CFG_ADDR_W = 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RADIUS      = 1'b0,
        REG_POINT_COUNT = 1'b1
    } cfg_reg_t;

    localparam int unsigned WORK_FRAC  = 30;
    localparam int unsigned TRIG_FRAC  = 24;
    localparam int unsigned THETA_W    = 31;
    localparam int unsigned X2_W       = 32;
    localparam int unsigned TERM_W     = 31;
    localparam int unsigned PROD_W     = 32;
    localparam int unsigned MAG_W      = 25;
    localparam int unsigned SCALED_W   = 17;
    localparam int unsigned HORNER_LEN = 8;

    localparam logic [THETA_W-1:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [TERM_W-1:0]  WORK_ONE    = 31'h4000_0000;

    typedef logic [8:0] hdiv_t;

    localparam hdiv_t SIN_DIV [HORNER_LEN] = '{9'd272, 9'd210, 9'd156, 9'd110,
                                               9'd72, 9'd42, 9'd20, 9'd6};
    localparam hdiv_t COS_DIV [HORNER_LEN] = '{9'd240, 9'd182, 9'd132, 9'd90,
                                               9'd56, 9'd30, 9'd12, 9'd2};

    function automatic hdiv_t horner_div(input logic lane, input logic [2:0] k);
        return lane ? COS_DIV[k] : SIN_DIV[k];
    endfunction

endpackage

// File: rtl/core/circle_point_generator_unit.sv
// ----------------------------------------------------------------------------
// circle_point_generator_unit
// Vertex coordinates of an n-point polygon on a circle centered at the origin.
// ----------------------------------------------------------------------------
// Fully pipelined: one index word is taken every cycle while the output is
// not stalled. The pipeline holds the restoring angle divider, four
// quotient bits per stage, followed by eight sine/cosine Horner steps of
// three stages each (multiply, reciprocal multiply, correct) and the radius
// scaling. A stall at the output holds the whole pipeline. Write radius and
// point_count only while the pipeline is empty. An index at or above
// point_count yields zero coordinates with tuser set.
module circle_point_generator_unit #(
    parameter int unsigned COORD_BITS      = cpg_pkg::COORD_BITS_DEF,
    parameter int unsigned ANGLE_FRAC_BITS = cpg_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [cpg_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [cpg_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] point_index
    input  logic [7:0]                           s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [COORD_BITS-1:0] x_coord, [2*COORD_BITS-1:COORD_BITS] y_coord, zero pad
    output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_axis_tdata,
    // [0] index_out_of_range
    output logic                                 m_axis_tuser
);
    import cpg_pkg::*;

    localparam int unsigned AFB      = ANGLE_FRAC_BITS;
    localparam int unsigned DS       = (AFB + 3) / 4;
    localparam int unsigned T_SHIFT  = WORK_FRAC - (AFB - 2);
    localparam int unsigned ST_THETA = DS + 1;
    localparam int unsigned ST_S30   = DS + 2 + 3 * HORNER_LEN + 1;
    localparam int unsigned ST_RND   = ST_S30 + 1;
    localparam int unsigned ST_SCL   = ST_RND + 1;
    localparam int unsigned NST      = ST_SCL + 2;
    localparam int unsigned TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int unsigned HL       = 3 * HORNER_LEN + 1;

    logic [RADIUS_W-1:0] radius_reg;
    logic [COUNT_W-1:0]  point_count_reg;

    logic en;

    logic       vld_reg  [NST];
    logic       oor_reg  [NST];
    logic [1:0] quad_reg [NST];

    logic [COUNT_W-1:0] drem_reg [DS+1];
    logic [AFB-1:0]     dquo_reg [DS+1];

    logic [THETA_W-1:0] theta_reg;
    logic [THETA_W-1:0] th_line  [HL];
    logic [X2_W-1:0]    x2_line  [HL];

    logic [PROD_W-1:0]  hp_reg   [2][HORNER_LEN];
    logic [PROD_W-1:0]  hpb_reg  [2][HORNER_LEN];
    logic [PROD_W-1:0]  hq_reg   [2][HORNER_LEN];
    logic [TERM_W-1:0]  term_reg [2][HORNER_LEN];

    logic [THETA_W-1:0] s30_reg, c30_reg;
    logic [MAG_W-1:0]   xm_reg, ym_reg;
    logic               xn_reg, yn_reg, xn2_reg, yn2_reg;
    logic [SCALED_W-1:0] px_reg, py_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg;

    logic [AFB-3:0]         frac_c;
    logic [WORK_FRAC-1:0]   t_c;
    logic [MAG_W-1:0]       s_rnd, c_rnd;
    logic [32:0]            xv, yv;

    assign en            = !vld_reg[NST-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NST-1];
    assign m_axis_tuser  = oor_reg[NST-1];
    assign m_axis_tdata  = TDATA_W'({y_reg, x_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= '0;
            point_count_reg <= COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_RADIUS:      radius_reg      <= cfg_data[RADIUS_W-1:0];
                REG_POINT_COUNT: point_count_reg <= cfg_data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int st = 0; st < NST; st++)
            begin
                vld_reg[st] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int st = 1; st < NST; st++)
            begin
                vld_reg[st] <= vld_reg[st-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oor_reg[0]  <= s_axis_tdata >= point_count_reg;
            quad_reg[0] <= '0;
            drem_reg[0] <= s_axis_tdata;
            dquo_reg[0] <= '0;
            for (int st = 1; st < NST; st++)
            begin
                oor_reg[st] <= oor_reg[st-1];
                if (st == ST_THETA)
                    quad_reg[st] <= dquo_reg[DS][AFB-1:AFB-2];
                else
                    quad_reg[st] <= quad_reg[st-1];
            end
        end
    end

    // angle divider: a = floor(i * 2^AFB / n), four quotient bits per stage
    for (genvar s = 0; s < DS; s++)
    begin : g_div
        logic [COUNT_W-1:0] rem_c;
        logic [AFB-1:0]     quo_c;
        logic [COUNT_W:0]   dbl;

        always_comb
        begin
            rem_c = drem_reg[s];
            quo_c = dquo_reg[s];
            dbl   = '0;
            for (int j = 0; j < 4; j++)
            begin
                if (s * 4 + j < AFB)
                begin
                    dbl = {rem_c, 1'b0};
                    if (dbl >= {1'b0, point_count_reg})
                    begin
                        rem_c = COUNT_W'(dbl - {1'b0, point_count_reg});
                        quo_c = {quo_c[AFB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_c = dbl[COUNT_W-1:0];
                        quo_c = {quo_c[AFB-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drem_reg[s+1] <= rem_c;
                dquo_reg[s+1] <= quo_c;
            end
        end
    end

    always_comb
    begin
        frac_c = dquo_reg[DS][AFB-3:0];
        t_c    = WORK_FRAC'(frac_c) << T_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            theta_reg  <= THETA_W'((61'(t_c) * 61'(HALF_PI_Q30)) >> WORK_FRAC);
            th_line[0] <= theta_reg;
            x2_line[0] <= X2_W'((62'(theta_reg) * 62'(theta_reg)) >> WORK_FRAC);
            for (int j = 1; j < HL; j++)
            begin
                th_line[j] <= th_line[j-1];
                x2_line[j] <= x2_line[j-1];
            end
        end
    end

    // Horner steps: lane 0 sine, lane 1 cosine
    for (genvar ln = 0; ln < 2; ln++)
    begin : g_lane
        for (genvar k = 0; k < HORNER_LEN; k++)
        begin : g_step
            localparam hdiv_t       D   = horner_div(1'(ln), 3'(k));
            localparam logic [31:0] RCP = 32'(64'h1_0000_0000 / 64'(D));

            logic [TERM_W-1:0] prev_term;
            logic [PROD_W-1:0] rem_c;
            logic [PROD_W-1:0] q_c;

            if (k == 0)
            begin : g_first
                assign prev_term = WORK_ONE;
            end
            else
            begin : g_next
                assign prev_term = term_reg[ln][k-1];
            end

            always_comb
            begin
                rem_c = hpb_reg[ln][k] - PROD_W'(hq_reg[ln][k] * PROD_W'(D));
                q_c   = hq_reg[ln][k] + PROD_W'(rem_c >= PROD_W'(D));
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    hp_reg[ln][k]  <= PROD_W'((63'(x2_line[3*k]) * 63'(prev_term))
                                              >> WORK_FRAC);
                    hq_reg[ln][k]  <= PROD_W'((64'(hp_reg[ln][k]) * 64'(RCP)) >> 32);
                    hpb_reg[ln][k] <= hp_reg[ln][k];
                    if (q_c > PROD_W'(WORK_ONE))
                        term_reg[ln][k] <= '0;
                    else
                        term_reg[ln][k] <= WORK_ONE - TERM_W'(q_c);
                end
            end
        end
    end

    always_comb
    begin
        s_rnd = MAG_W'((32'(s30_reg) + 32'd32) >> (WORK_FRAC - TRIG_FRAC));
        c_rnd = MAG_W'((32'(c30_reg) + 32'd32) >> (WORK_FRAC - TRIG_FRAC));
        xv    = xn2_reg ? 33'(0) - 33'(px_reg) : 33'(px_reg);
        yv    = yn2_reg ? 33'(0) - 33'(py_reg) : 33'(py_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s30_reg <= THETA_W'((62'(th_line[HL-1]) * 62'(term_reg[0][HORNER_LEN-1]))
                                >> WORK_FRAC);
            c30_reg <= THETA_W'(term_reg[1][HORNER_LEN-1]);

            unique case (quad_reg[ST_RND-1])
                2'd0:
                begin
                    xm_reg <= c_rnd; xn_reg <= 1'b0; ym_reg <= s_rnd; yn_reg <= 1'b0;
                end
                2'd1:
                begin
                    xm_reg <= s_rnd; xn_reg <= 1'b1; ym_reg <= c_rnd; yn_reg <= 1'b0;
                end
                2'd2:
                begin
                    xm_reg <= c_rnd; xn_reg <= 1'b1; ym_reg <= s_rnd; yn_reg <= 1'b1;
                end
                default:
                begin
                    xm_reg <= s_rnd; xn_reg <= 1'b0; ym_reg <= c_rnd; yn_reg <= 1'b1;
                end
            endcase

            px_reg  <= SCALED_W'((40'(radius_reg) * 40'(xm_reg)) >> TRIG_FRAC);
            py_reg  <= SCALED_W'((40'(radius_reg) * 40'(ym_reg)) >> TRIG_FRAC);
            xn2_reg <= xn_reg;
            yn2_reg <= yn_reg;

            x_reg <= oor_reg[NST-2] ? '0 : xv[COORD_BITS-1:0];
            y_reg <= oor_reg[NST-2] ? '0 : yv[COORD_BITS-1:0];
        end
    end

endmodule

// File: rtl/core/cpg_checker.sv
// ----------------------------------------------------------------------------
// cpg_checker
// Port-level checks for the circle point generator.
// ----------------------------------------------------------------------------
module cpg_checker #(
    parameter int unsigned COORD_BITS = cpg_pkg::COORD_BITS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    input logic                              m_axis_tuser
);

    // out-of-range words carry zero coordinates
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("out-of-range word with nonzero coordinates");

    // a blocked output holds the input side
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

endmodule

bind circle_point_generator_unit cpg_checker #(.COORD_BITS(COORD_BITS)) u_cpg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
